/* rtl/core/ikht_pkg.sv */
// ----------------------------------------------------------------------------
// ikht_pkg
// Shared types and constants of the integer-key chained hash table.
// ----------------------------------------------------------------------------
package ikht_pkg;

    localparam int MAX_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 1024;
    localparam int BKT_W        = $clog2(MAX_BUCKETS);
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 64;
    localparam int CFG_W        = 4;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);
    localparam logic [CFG_W-1:0]  BITS_MIN  = CFG_W'(3);
    localparam logic [CFG_W-1:0]  BITS_MAX  = CFG_W'(BKT_W);
    localparam logic [CFG_W-1:0]  BITS_RST  = CFG_W'(8);

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_FIND = 2'd1,
        MODE_DEL  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_CMP,
        ST_DO,
        ST_ALLOC,
        ST_DEL2,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_mode             mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [BKT_W-1:0]  bkt;
    } t_req;

endpackage

/* rtl/core/ikht_ram.sv */
// ----------------------------------------------------------------------------
// ikht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ikht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ikht_front.sv */
// ----------------------------------------------------------------------------
// ikht_front
// Accepts requests, works out the bucket index and queues them for the back.
// ----------------------------------------------------------------------------
module ikht_front import ikht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_bucket_bits,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_mode,
    input  logic [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0] i_new_value,
    output logic             o_q_valid,
    input  logic             i_q_ready,
    output t_req             o_q_data
);

    t_req             r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic [CFG_W-1:0] eff_bits;
    logic [BKT_W:0]   mask;
    t_req             req;
    logic             push;
    logic             pop;

    always_comb begin
        if (i_bucket_bits < BITS_MIN) begin
            eff_bits = BITS_MIN;
        end else if (i_bucket_bits > BITS_MAX) begin
            eff_bits = BITS_MAX;
        end else begin
            eff_bits = i_bucket_bits;
        end
        mask      = ((BKT_W+1)'(1) << eff_bits) - (BKT_W+1)'(1);
        req.mode  = t_mode'(i_mode);
        req.key   = i_key;
        req.value = i_new_value;
        req.bkt   = i_key[BKT_W-1:0] & mask[BKT_W-1:0];
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_q[r_rp];
    assign push       = i_in_valid & o_in_ready;
    assign pop        = o_q_valid & i_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/core/ikht_back.sv */
// ----------------------------------------------------------------------------
// ikht_back
// Walks the bucket chain, applies add, find or delete and holds the result.
// ----------------------------------------------------------------------------
module ikht_back import ikht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_req              i_q_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [VAL_W-1:0]  o_found_value,
    output logic [LINK_W-1:0] o_element_count
);

    t_state              r_state, n_state;
    t_req                r_req;
    logic [LINK_W-1:0]   r_cur, r_prev, r_steps, r_head, r_cur_link;
    logic [VAL_W-1:0]    r_cur_val;
    logic                r_found, r_ok;
    logic [LINK_W-1:0]   r_fresh, r_recyc, r_count;
    logic [MAX_BUCKETS-1:0] r_head_vld;
    logic                r_o_valid, r_o_ok;
    logic [VAL_W-1:0]    r_o_fv;
    logic [LINK_W-1:0]   r_o_cnt;

    logic [LINK_W-1:0]   head_rdata, head_val, link_rdata, steps_n;
    logic [KEY_W-1:0]    key_rdata;
    logic [VAL_W-1:0]    val_rdata;
    logic [BKT_W-1:0]    head_raddr;
    logic [IDX_W-1:0]    rd_addr;
    logic                head_we, key_we, val_we, link_we;
    logic [LINK_W-1:0]   head_wdata, link_wdata;
    logic [IDX_W-1:0]    key_waddr, val_waddr, link_waddr;
    logic                hit, walk_end, out_free;
    logic [LINK_W-1:0]   new_e;

    assign head_val = r_head_vld[r_req.bkt] ? head_rdata : NULL_LINK;
    assign steps_n  = r_steps + LINK_W'(1);
    assign hit      = (key_rdata == r_req.key);
    assign walk_end = link_rdata[IDX_W] | (steps_n == LINK_W'(POOL_ENTRIES));
    assign out_free = !r_o_valid || i_out_ready;
    assign new_e    = (r_state == ST_ALLOC) ? r_recyc : r_fresh;

    ikht_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(r_req.bkt), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    ikht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(r_req.key),
        .i_raddr(rd_addr), .o_rdata(key_rdata)
    );
    ikht_ram #(.WIDTH(VAL_W), .DEPTH(POOL_ENTRIES)) u_val (
        .i_clk(i_clk), .i_we(val_we), .i_waddr(val_waddr), .i_wdata(r_req.value),
        .i_raddr(rd_addr), .o_rdata(val_rdata)
    );
    ikht_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(rd_addr), .o_rdata(link_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                n_state = head_val[IDX_W] ? ST_DO : ST_CMP;
            end
            ST_CMP: begin
                if (hit || walk_end) begin
                    n_state = ST_DO;
                end
            end
            ST_DO: begin
                if (r_req.mode == MODE_ADD && !r_found && !r_recyc[IDX_W]) begin
                    n_state = ST_ALLOC;
                end else if (r_req.mode == MODE_DEL && r_found) begin
                    n_state = ST_DEL2;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_ALLOC: n_state = ST_FIN;
            ST_DEL2:  n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        o_q_ready  = 1'b0;
        head_raddr = i_q_data.bkt;
        rd_addr    = head_val[IDX_W-1:0];
        head_we    = 1'b0;
        head_wdata = new_e;
        key_we     = 1'b0;
        key_waddr  = new_e[IDX_W-1:0];
        val_we     = 1'b0;
        val_waddr  = new_e[IDX_W-1:0];
        link_we    = 1'b0;
        link_waddr = new_e[IDX_W-1:0];
        link_wdata = r_head;
        case (r_state)
            ST_IDLE: o_q_ready = 1'b1;
            ST_CMP:  rd_addr   = link_rdata[IDX_W-1:0];
            ST_DO: begin
                rd_addr = r_recyc[IDX_W-1:0];
                case (r_req.mode)
                    MODE_ADD: begin
                        if (r_found) begin
                            val_we    = 1'b1;
                            val_waddr = r_cur[IDX_W-1:0];
                        end else if (r_recyc[IDX_W] && !r_fresh[IDX_W]) begin
                            head_we = 1'b1;
                            key_we  = 1'b1;
                            val_we  = 1'b1;
                            link_we = 1'b1;
                        end
                    end
                    MODE_DEL: begin
                        if (r_found) begin
                            if (!r_prev[IDX_W]) begin
                                link_we    = 1'b1;
                                link_waddr = r_prev[IDX_W-1:0];
                                link_wdata = r_cur_link;
                            end else begin
                                head_we    = 1'b1;
                                head_wdata = r_cur_link;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_ALLOC: begin
                head_we = 1'b1;
                key_we  = 1'b1;
                val_we  = 1'b1;
                link_we = 1'b1;
            end
            ST_DEL2: begin
                link_we    = 1'b1;
                link_waddr = r_cur[IDX_W-1:0];
                link_wdata = r_recyc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_req <= i_q_data;
                end
            end
            ST_HEAD: begin
                r_head  <= head_val;
                r_cur   <= head_val;
                r_prev  <= NULL_LINK;
                r_steps <= '0;
                r_found <= 1'b0;
            end
            ST_CMP: begin
                if (hit) begin
                    r_found    <= 1'b1;
                    r_cur_link <= link_rdata;
                    r_cur_val  <= val_rdata;
                end else begin
                    r_prev  <= r_cur;
                    r_cur   <= link_rdata;
                    r_steps <= steps_n;
                end
            end
            ST_DO: begin
                r_ok <= r_found && r_req.mode != MODE_NONE;
                if (r_req.mode == MODE_ADD && !r_found) begin
                    r_ok <= !r_recyc[IDX_W] || !r_fresh[IDX_W];
                end
            end
            default: ;
        endcase
        if (r_state == ST_FIN && out_free) begin
            r_o_ok  <= r_ok;
            r_o_cnt <= r_count;
            r_o_fv  <= (r_req.mode == MODE_FIND && r_found) ? r_cur_val : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fresh    <= '0;
            r_recyc    <= NULL_LINK;
            r_count    <= '0;
            r_head_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (head_we) begin
                r_head_vld[r_req.bkt] <= 1'b1;
            end
            if (r_state == ST_DO && r_req.mode == MODE_ADD && !r_found
                    && r_recyc[IDX_W] && !r_fresh[IDX_W]) begin
                r_fresh <= r_fresh + LINK_W'(1);
                r_count <= r_count + LINK_W'(1);
            end
            if (r_state == ST_ALLOC) begin
                r_recyc <= link_rdata;
                r_count <= r_count + LINK_W'(1);
            end
            if (r_state == ST_DEL2) begin
                r_recyc <= r_cur;
                if (r_count != '0) begin
                    r_count <= r_count - LINK_W'(1);
                end
            end
            if (r_state == ST_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_ok            = r_o_ok;
    assign o_found_value   = r_o_fv;
    assign o_element_count = r_o_cnt;

endmodule

/* rtl/core/int_key_chained_hash_table_core.sv */
// ----------------------------------------------------------------------------
// int_key_chained_hash_table_core
// Hash map of 32-bit keys to 64-bit values over a 1024-entry chained pool.
// ----------------------------------------------------------------------------
// A request passes IDLE, HEAD, one CMP per chain entry visited, DO and FIN;
// add of a recycled entry adds ALLOC, a delete that removes an entry DEL2.
// The walk reads one entry a cycle over the single read port of the entry
// memories. Two requests queue ahead of the walker; a result waits in an
// output register while the next request is walked.
module int_key_chained_hash_table_core import ikht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_new_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_ok,
    output logic [VAL_W-1:0]  o_found_value,
    output logic [LINK_W-1:0] o_element_count
);

    logic [CFG_W-1:0] r_bucket_bits;
    logic             q_valid;
    logic             q_ready;
    t_req             q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= BITS_RST;
        end else if (i_cfg_valid) begin
            r_bucket_bits <= i_cfg_data;
        end
    end

    ikht_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bucket_bits(r_bucket_bits),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_mode(i_mode),
        .i_key(i_key), .i_new_value(i_new_value),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_data(q_data)
    );

    ikht_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_data(q_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_ok(o_ok),
        .o_found_value(o_found_value), .o_element_count(o_element_count)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_element_count <= LINK_W'(POOL_ENTRIES))
        else $error("element count beyond pool size");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> o_found_value == '0)
        else $error("value returned on a failed request");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown right after reset");

endmodule
